/* hdl/lse_pkg.sv */
`timescale 1ns / 1ps
package lse_pkg;
    localparam int LINE_CAPACITY_DEF = 256;
    localparam int LINE_BYTES_DEF = 256;
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_END = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [1:0] CFG_SEED = 2'd0;
    localparam logic [1:0] CFG_LIMIT_ON = 2'd1;
    localparam logic [1:0] CFG_LIMIT_LINES = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_byte;   // store data byte
        logic close_line;  // newline or end with partial line
        logic shuf_init;   // load generator from seed
        logic lcg_step;    // advance generator, start modulo
        logic rd_hi;       // read index table at j-1 and k
        logic swap;        // write back entry j-1
        logic swap_k;      // write back entry k, step j down
        logic emit_init;   // clear emit pointers
        logic fetch_rd;    // read line entry for fetch
        logic fetch_byte;  // read byte store for fetch
        logic fetch_done;  // form result and advance
    } lse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic more_shuf;   // j > 1
        logic div_busy;
        logic emit_avail;  // an output byte remains
        logic full;        // line table full
        logic len_max;     // current line at its byte limit
        logic has_part;    // current line holds bytes
    } lse_stat_t;
endpackage

/* hdl/lse_datapath.sv */
`timescale 1ns / 1ps
module lse_datapath
    import lse_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lse_cmd_t    cmd,
    output lse_stat_t   stat,
    input  logic [7:0]  data_byte,
    input  logic [31:0] seed,
    input  logic        limit_on,
    input  logic [8:0]  limit_lines,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        empty_res
);
    localparam int STORE = LINE_CAPACITY * LINE_BYTES;
    localparam int AW = $clog2(STORE);
    localparam int LW = $clog2(LINE_CAPACITY);
    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int BW = $clog2(LINE_BYTES);
    localparam int OW = $clog2(LINE_BYTES + 1);

    logic [7:0]    byte_mem [STORE];
    logic [AW-1:0] start_mem [LINE_CAPACITY];
    logic [BW-1:0] len_mem [LINE_CAPACITY];

    logic [CW-1:0] held_reg;
    logic [AW-1:0] wpos_reg;
    logic [BW-1:0] cur_len_reg;
    logic [31:0]   gen_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] eline_reg;
    logic [OW-1:0] eoff_reg;
    logic [AW-1:0] rs_a_reg, rs_b_reg;
    logic [BW-1:0] rl_a_reg, rl_b_reg;
    logic [7:0]    rbyte_reg;
    logic [7:0]    obyte_reg;
    logic          olast_reg, oempty_reg;

    logic [31:0] gen_next;
    logic [CW-1:0] total;
    logic full;
    logic [AW:0]   wr_sum, rd_sum;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [LW-1:0] hi_idx, k_idx;
    logic [CW-1:0] k_full;

    // shift-subtract modulo of the generator output by j
    logic [5:0]  div_cnt_reg;
    logic [31:0] div_num_reg;
    logic [CW:0] div_rem_reg;
    logic [CW:0] div_try;

    assign full = (held_reg == CW'(LINE_CAPACITY));
    assign total = (limit_on && (32'(limit_lines) < 32'(held_reg)))
                   ? CW'(limit_lines) : held_reg;

    // store addresses wrap at the store size
    assign wr_sum = {1'b0, wpos_reg} + (AW+1)'(cur_len_reg);
    assign wr_addr = (wr_sum >= (AW+1)'(STORE)) ? AW'(wr_sum - (AW+1)'(STORE))
                                                 : AW'(wr_sum);
    assign rd_sum = {1'b0, rs_a_reg} + (AW+1)'(eoff_reg);
    assign rd_addr = (rd_sum >= (AW+1)'(STORE)) ? AW'(rd_sum - (AW+1)'(STORE))
                                                 : AW'(rd_sum);

    assign gen_next = gen_reg * LCG_MUL + LCG_ADD;
    assign hi_idx = LW'(j_reg - CW'(1));
    assign div_try = {div_rem_reg[CW-1:0], div_num_reg[31]};
    assign k_full = div_rem_reg[CW-1:0];
    assign k_idx = LW'(k_full);

    assign stat.more_shuf = (j_reg > CW'(1));
    assign stat.div_busy = (div_cnt_reg != 6'd0);
    assign stat.emit_avail = (eline_reg < total);
    assign stat.full = full;
    assign stat.len_max = (cur_len_reg == BW'(LINE_BYTES - 1));
    assign stat.has_part = (cur_len_reg != '0);

    // byte store
    always_ff @(posedge aclk) begin
        if (cmd.load_byte)
            byte_mem[wr_addr] <= data_byte;
        if (cmd.fetch_byte)
            rbyte_reg <= byte_mem[rd_addr];
    end

    // line tables: one write port per table, used for both swap halves in turn
    always_ff @(posedge aclk) begin
        if (cmd.close_line && !full) begin
            start_mem[LW'(held_reg)] <= wpos_reg;
            len_mem[LW'(held_reg)] <= cur_len_reg;
        end
        if (cmd.rd_hi) begin
            rs_a_reg <= start_mem[hi_idx];
            rl_a_reg <= len_mem[hi_idx];
            rs_b_reg <= start_mem[k_idx];
            rl_b_reg <= len_mem[k_idx];
        end
        if (cmd.swap) begin
            start_mem[hi_idx] <= rs_b_reg;
            len_mem[hi_idx] <= rl_b_reg;
        end
        if (cmd.swap_k) begin
            start_mem[k_idx] <= rs_a_reg;
            len_mem[k_idx] <= rl_a_reg;
        end
        if (cmd.fetch_rd) begin
            rs_a_reg <= start_mem[LW'(eline_reg)];
            rl_a_reg <= len_mem[LW'(eline_reg)];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            wpos_reg <= '0;
            cur_len_reg <= '0;
            gen_reg <= '0;
            j_reg <= '0;
            eline_reg <= '0;
            eoff_reg <= '0;
            div_cnt_reg <= '0;
            olast_reg <= 1'b0;
            oempty_reg <= 1'b1;
            obyte_reg <= '0;
        end else begin
            if (cmd.load_byte)
                cur_len_reg <= cur_len_reg + BW'(1);
            if (cmd.close_line) begin
                if (!full) begin
                    held_reg <= held_reg + CW'(1);
                    wpos_reg <= wr_addr;
                end
                cur_len_reg <= '0;
            end
            if (cmd.shuf_init) begin
                gen_reg <= seed;
                j_reg <= held_reg;
            end
            if (cmd.lcg_step) begin
                gen_reg <= gen_next;
                div_num_reg <= gen_next;
                div_rem_reg <= '0;
                div_cnt_reg <= 6'd32;
            end else if (div_cnt_reg != 6'd0) begin
                div_num_reg <= {div_num_reg[30:0], 1'b0};
                div_rem_reg <= (div_try >= {1'b0, j_reg}) ? div_try - {1'b0, j_reg}
                                                         : div_try;
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            if (cmd.swap_k)
                j_reg <= j_reg - CW'(1);
            if (cmd.emit_init) begin
                eline_reg <= '0;
                eoff_reg <= '0;
            end
            if (cmd.fetch_done) begin
                oempty_reg <= 1'b0;
                olast_reg <= 1'b0;
                if (OW'(rl_a_reg) > eoff_reg) begin
                    obyte_reg <= rbyte_reg;
                    eoff_reg <= eoff_reg + OW'(1);
                end else begin
                    obyte_reg <= NEWLINE;
                    olast_reg <= (eline_reg + CW'(1) == total);
                    eline_reg <= eline_reg + CW'(1);
                    eoff_reg <= '0;
                end
            end else if (cmd.fetch_rd && !(eline_reg < total)) begin
                oempty_reg <= 1'b1;
                olast_reg <= 1'b0;
                obyte_reg <= '0;
            end
        end
    end

    assign out_byte = obyte_reg;
    assign last_byte = olast_reg;
    assign empty_res = oempty_reg;
endmodule

/* hdl/lse_ctrl.sv */
`timescale 1ns / 1ps
module lse_ctrl
    import lse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output lse_cmd_t   cmd,
    input  lse_stat_t  stat
);
    typedef enum logic [3:0] {
        S_LOAD, S_SH_INIT, S_SH_STEP, S_SH_DIV, S_SH_RD, S_SH_SWAP, S_SH_SWAP_K,
        S_EMIT, S_F_RD, S_F_BYTE, S_F_DONE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic emitting_reg, emitting_next;
    logic acc;

    assign acc = s_valid && s_ready;
    assign s_ready = (state_reg == S_LOAD) || (state_reg == S_EMIT);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        emitting_next = emitting_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (acc) begin
                    if (s_mode == MODE_DATA) begin
                        if (s_data_byte == NEWLINE)
                            cmd.close_line = 1'b1;
                        else if (s_data_byte != 8'd0 && !stat.full && !stat.len_max)
                            cmd.load_byte = 1'b1;
                    end else if (s_mode == MODE_END) begin
                        cmd.close_line = stat.has_part;
                        state_next = S_SH_INIT;
                    end else if (s_mode == MODE_FETCH) begin
                        cmd.fetch_rd = 1'b1;
                        state_next = S_F_RD;
                    end
                end
            end
            S_SH_INIT: begin
                cmd.shuf_init = 1'b1;
                state_next = S_SH_STEP;
            end
            S_SH_STEP: begin
                if (stat.more_shuf) begin
                    cmd.lcg_step = 1'b1;
                    state_next = S_SH_DIV;
                end else begin
                    cmd.emit_init = 1'b1;
                    emitting_next = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_SH_DIV: if (!stat.div_busy) state_next = S_SH_RD;
            S_SH_RD: begin
                cmd.rd_hi = 1'b1;
                state_next = S_SH_SWAP;
            end
            S_SH_SWAP: begin
                cmd.swap = 1'b1;
                state_next = S_SH_SWAP_K;
            end
            S_SH_SWAP_K: begin
                cmd.swap_k = 1'b1;
                state_next = S_SH_STEP;
            end
            S_EMIT: begin
                if (acc && s_mode == MODE_FETCH) begin
                    cmd.fetch_rd = 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_F_RD: begin
                if (emitting_reg && stat.emit_avail) begin
                    cmd.fetch_byte = 1'b1;
                    state_next = S_F_BYTE;
                end else
                    state_next = S_OUT;
            end
            S_F_BYTE: begin
                cmd.fetch_done = 1'b1;
                state_next = S_OUT;
            end
            S_F_DONE: state_next = S_OUT;
            S_OUT: if (m_ready) state_next = emitting_reg ? S_EMIT : S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            emitting_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            emitting_reg <= emitting_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_no_accept_shuf: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |-> !s_ready) else $error("accept during shuffle");
    a_load_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_byte |-> !emitting_reg) else $error("load after end");
endmodule

/* hdl/line_shuffle_engine_top.sv */
`timescale 1ns / 1ps
// Data transactions are accepted back to back while loading.
// End runs the shuffle; each swap is a generator step, the shift-subtract
// modulo unit, a table read and two write-backs (entry j-1, then entry k).
// Fetch: the line entry is read, then the byte store, then the result is
// formed (no byte read when empty); the next fetch waits for the result.
// aresetn is synchronous, active low; clears control state, configuration and output registers.
module line_shuffle_engine_top
    import lse_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte,
    output logic        m_empty_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] seed_reg;
    logic        limit_on_reg;
    logic [8:0]  limit_lines_reg;
    lse_cmd_t    cmd;
    lse_stat_t   stat;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            limit_on_reg <= 1'b0;
            limit_lines_reg <= 9'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SEED:        seed_reg <= cfg_data;
                CFG_LIMIT_ON:    limit_on_reg <= cfg_data[0];
                CFG_LIMIT_LINES: limit_lines_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    lse_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_data_byte,
        .m_valid, .m_ready, .cmd, .stat
    );

    lse_datapath #(.LINE_CAPACITY(LINE_CAPACITY), .LINE_BYTES(LINE_BYTES)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .data_byte(s_data_byte),
        .seed(seed_reg), .limit_on(limit_on_reg), .limit_lines(limit_lines_reg),
        .out_byte(m_out_byte), .last_byte(m_last_byte), .empty_res(m_empty_res)
    );
endmodule

/* dv/line_shuffle_engine_top_tb.sv */
`timescale 1ns / 1ps
module line_shuffle_engine_top_tb;
    import lse_pkg::*;

    localparam int CAP        = 256;
    localparam int LBYTES     = 256;
    localparam int STORE      = CAP * LBYTES;
    localparam int CYCLE_CAP  = 600000;
    localparam int SHUF_WAIT  = 40 * CAP + 200;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       empty_res;
    } shuf_out_t;

    // scoreboard: line store model, shuffle and output predictor
    class shuffle_scoreboard;
        logic [7:0]  bytes_q [STORE];
        logic [15:0] start_q [CAP];
        logic [7:0]  len_q   [CAP];
        int unsigned held, wpos, cur_len, eline, eoff;
        logic [31:0] gen, seed;
        logic        emitting, lim_on;
        logic [8:0]  lim_lines;
        shuf_out_t   due_q [$];
        int          errors;

        function new();
            held = 0; wpos = 0; cur_len = 0; eline = 0; eoff = 0;
            gen = 0; seed = 0; emitting = 0; lim_on = 0; lim_lines = 9'd256;
            errors = 0;
        endfunction

        function void note_config(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_SEED:        seed = val;
                CFG_LIMIT_ON:    lim_on = val[0];
                CFG_LIMIT_LINES: lim_lines = val[8:0];
                default: ;
            endcase
        endfunction

        function void close_line();
            if (held < CAP) begin
                start_q[held] = wpos[15:0];
                len_q[held]   = cur_len[7:0];
                held++;
                wpos = (wpos + cur_len) % STORE;
            end
            cur_len = 0;
        endfunction

        function int unsigned out_total();
            if (lim_on && lim_lines < held) return lim_lines;
            return held;
        endfunction

        function bit exhausted();
            return emitting && eline >= out_total();
        endfunction

        // accepted input transaction
        function void note_input(logic [1:0] mode, logic [7:0] ch);
            int unsigned j, k;
            logic [15:0] ts;
            logic [7:0]  tl;
            shuf_out_t   r;
            case (mode)
                MODE_DATA: begin
                    if (emitting || ch == 8'd0) return;
                    if (ch == NEWLINE) close_line();
                    else if (held < CAP && cur_len < LBYTES - 1) begin
                        bytes_q[(wpos + cur_len) % STORE] = ch;
                        cur_len++;
                    end
                end
                MODE_END: begin
                    if (emitting) return;
                    if (cur_len > 0) close_line();
                    cur_len = 0;
                    // Fisher-Yates, generator restarted from the seed
                    gen = seed;
                    for (j = held; j > 1; j--) begin
                        gen = gen * LCG_MUL + LCG_ADD;
                        k = gen % j;
                        ts = start_q[j-1]; tl = len_q[j-1];
                        start_q[j-1] = start_q[k]; len_q[j-1] = len_q[k];
                        start_q[k] = ts; len_q[k] = tl;
                    end
                    emitting = 1; eline = 0; eoff = 0;
                end
                MODE_FETCH: begin
                    r = '{out_byte: 8'd0, last_byte: 1'b0, empty_res: 1'b1};
                    if (emitting && eline < out_total() && eline < CAP) begin
                        r.empty_res = 1'b0;
                        if (eoff < len_q[eline]) begin
                            r.out_byte = bytes_q[(start_q[eline] + eoff) % STORE];
                            eoff++;
                        end else begin
                            r.out_byte  = NEWLINE;
                            r.last_byte = (eline + 1 == out_total());
                            eline++;
                            eoff = 0;
                        end
                    end
                    due_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // accepted result transaction
        function void check_result(shuf_out_t got);
            shuf_out_t want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: byte=%0d last=%0b empty=%0b",
                             got.out_byte, got.last_byte, got.empty_res);
                return;
            end
            want = due_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp byte=%0d last=%0b empty=%0b, got byte=%0d last=%0b empty=%0b",
                             want.out_byte, want.last_byte, want.empty_res,
                             got.out_byte, got.last_byte, got.empty_res);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_DATA;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_byte;
    logic        m_empty_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SEED;
    logic [31:0] cfg_data = 32'd0;

    shuffle_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;

    line_shuffle_engine_top uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("line_shuffle_engine_top_tb NOT OK");
            $finish;
        end
    end

    // monitor all three channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_input(s_mode, s_data_byte);
            if (m_valid && m_ready)
                sb.check_result('{m_out_byte, m_last_byte, m_empty_res});
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(logic [1:0] mode, logic [7:0] ch);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_data_byte <= ch;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 99) == 0) calm = !calm;
    endtask

    task automatic settle(int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic fetch_run(int n);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0)
                send_item($urandom_range(0, 1) ? MODE_RSVD : MODE_DATA,
                          8'($urandom_range(0, 255)));
            else
                send_item(MODE_FETCH, 8'd0);
        end
    endtask

    initial begin
        int len, extra_lines;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cfg_write(CFG_SEED, 32'd0);
        cfg_write(CFG_LIMIT_ON, 32'd0);
        cfg_write(CFG_LIMIT_LINES, 32'd256);

        // directed: fetch while loading, ignored codes, empty and edge lines
        send_item(MODE_FETCH, 8'd0);
        send_item(MODE_RSVD, 8'hFF);
        send_item(MODE_DATA, 8'd0);
        send_item(MODE_DATA, NEWLINE);
        send_item(MODE_DATA, 8'd255);
        send_item(MODE_DATA, 8'd1);
        send_item(MODE_DATA, NEWLINE);
        send_item(MODE_DATA, NEWLINE);

        // long line, clipped to LBYTES-1 bytes
        repeat (300) send_item(MODE_DATA, 8'($urandom_range(11, 255)));
        send_item(MODE_DATA, NEWLINE);

        // mostly very short random lines until eight of them have ended with the line table full
        extra_lines = 0;
        while (extra_lines < 8) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20)
                                                : $urandom_range(0, 1);
            repeat (len) begin
                if ($urandom_range(0, 49) == 0)
                    send_item($urandom_range(0, 1) ? MODE_RSVD : MODE_FETCH, 8'd0);
                else
                    send_item(MODE_DATA, 8'($urandom_range(0, 255)));
            end
            send_item(MODE_DATA, NEWLINE);
            if (sb.held >= CAP) extra_lines++;
        end
        // partial line at the end (dropped, line table full)
        send_item(MODE_DATA, 8'h41);

        settle(8);
        cfg_write(CFG_SEED, $urandom);

        send_item(MODE_END, 8'd0);
        // ignored once emitting
        send_item(MODE_DATA, 8'h55);
        send_item(MODE_END, 8'd0);
        settle(SHUF_WAIT);

        // limit of zero: nothing to emit
        cfg_write(CFG_LIMIT_ON, 32'd1);
        cfg_write(CFG_LIMIT_LINES, 32'd0);
        fetch_run(3);
        settle(8);

        // limit above the line count, then unlimited
        cfg_write(CFG_LIMIT_LINES, 32'd511);
        fetch_run(300);
        settle(8);
        cfg_write(CFG_LIMIT_ON, 32'd0);
        fetch_run(200);
        settle(8);

        // limit part way through the output
        cfg_write(CFG_LIMIT_ON, 32'd1);
        cfg_write(CFG_LIMIT_LINES, $urandom_range(150, 230));
        while (!sb.exhausted()) begin
            fetch_run(1);
            @(posedge aclk);
        end
        fetch_run(3);
        settle(8);

        // remove the limit and drain to the end
        cfg_write(CFG_LIMIT_ON, 32'd0);
        while (!sb.exhausted()) begin
            fetch_run(1);
            @(posedge aclk);
        end
        fetch_run(5);
        settle(20);

        if (sb.errors == 0) begin
            $display("line_shuffle_engine_top_tb OK");
        end else begin
            $display("line_shuffle_engine_top_tb NOT OK");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/lse_pkg.sv
hdl/lse_datapath.sv
hdl/lse_ctrl.sv
hdl/line_shuffle_engine_top.sv
dv/line_shuffle_engine_top_tb.sv
